// ===== rtl/tmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared types and constants for the telematics message framer.
// ----------------------------------------------------------------------------
package tmf_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h02;
    localparam logic [7:0] ESC_ESC   = 8'h01;

    localparam int TID_W     = 48;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef struct packed {
        logic [15:0] message_id;
        logic [15:0] attribute_word;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        first_item;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic        first_item;
        logic        has_data;
        logic        last_item;
        logic [15:0] message_id;
        logic [15:0] attribute_word;
        logic [7:0]  data_byte;
        logic [15:0] seq_num;
    } t_cmd;

endpackage

// ===== rtl/tmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_front
// Accepts requests, tracks message state and the sequence number, and queues
// a command for every request that produces wire bytes.
// ----------------------------------------------------------------------------
module tmf_front import tmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    logic        r_inside;
    logic [15:0] r_seq;
    logic        accept;
    logic        open_now;

    assign o_full   = i_cmd_full;
    assign accept   = i_push && !i_cmd_full;
    assign open_now = i_item.first_item || r_inside;

    assign o_cmd_push = accept && open_now &&
                        (i_item.first_item || i_item.has_data || i_item.last_item);

    always_comb begin
        o_cmd.first_item     = i_item.first_item;
        o_cmd.has_data       = i_item.has_data;
        o_cmd.last_item      = i_item.last_item;
        o_cmd.message_id     = i_item.message_id;
        o_cmd.attribute_word = i_item.attribute_word;
        o_cmd.data_byte      = i_item.data_byte;
        o_cmd.seq_num        = r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_seq    <= '0;
        end else if (accept) begin
            if (i_item.first_item) begin
                r_seq <= r_seq + 16'd1;
            end
            if (open_now && i_item.last_item) begin
                r_inside <= 1'b0;
            end else if (i_item.first_item) begin
                r_inside <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tmf_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_cmd_fifo
// Small command queue between the front and back halves.
// ----------------------------------------------------------------------------
module tmf_cmd_fifo import tmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wr_ptr;
    logic [CMDQ_AW-1:0]  r_rd_ptr;
    logic [CMDQ_AW:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (CMDQ_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (CMDQ_AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/tmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_back
// Walks each queued command byte by byte: flag, header, body, checksum and
// closing flag, with escaping and checksum accumulation, into an output stage.
// ----------------------------------------------------------------------------
module tmf_back import tmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    input  logic [TID_W-1:0] i_device_code,
    output t_out_item        o_item,
    output logic             o_empty,
    input  logic             i_pop
);

    localparam logic [3:0] STEP_FLAG     = 4'd0;
    localparam logic [3:0] STEP_HDR_LAST = 4'd12;
    localparam logic [3:0] STEP_DATA     = 4'd13;
    localparam logic [3:0] STEP_CHK      = 4'd14;
    localparam logic [3:0] STEP_CLOSE    = 4'd15;

    logic       r_mid;
    logic       r_esc;
    logic [3:0] r_step;
    logic [7:0] r_xor;
    t_out_item  r_out;
    logic       r_out_valid;

    logic [3:0] step;
    logic [3:0] step_start;
    logic [3:0] step_next;
    logic       has_next;
    logic [7:0] raw;
    logic       is_content;
    logic       need_esc;
    logic       finishing;
    logic       final_byte;
    logic [7:0] wire_byte;
    logic       adv;

    assign adv = !i_cmd_empty && (!r_out_valid || i_pop);

    always_comb begin
        if (i_cmd.first_item) begin
            step_start = STEP_FLAG;
        end else if (i_cmd.has_data) begin
            step_start = STEP_DATA;
        end else begin
            step_start = STEP_CHK;
        end
        step = r_mid ? r_step : step_start;

        case (step)
            STEP_FLAG:     raw = FLAG_BYTE;
            4'd1:          raw = i_cmd.message_id[15:8];
            4'd2:          raw = i_cmd.message_id[7:0];
            4'd3:          raw = i_cmd.attribute_word[15:8];
            4'd4:          raw = i_cmd.attribute_word[7:0];
            4'd5:          raw = i_device_code[47:40];
            4'd6:          raw = i_device_code[39:32];
            4'd7:          raw = i_device_code[31:24];
            4'd8:          raw = i_device_code[23:16];
            4'd9:          raw = i_device_code[15:8];
            4'd10:         raw = i_device_code[7:0];
            4'd11:         raw = i_cmd.seq_num[15:8];
            STEP_HDR_LAST: raw = i_cmd.seq_num[7:0];
            STEP_DATA:     raw = i_cmd.data_byte;
            STEP_CHK:      raw = r_xor;
            default:       raw = FLAG_BYTE;
        endcase

        is_content = (step != STEP_FLAG) && (step <= STEP_DATA);
        need_esc   = (step != STEP_FLAG) && (step != STEP_CLOSE) &&
                     ((raw == FLAG_BYTE) || (raw == ESC_BYTE));

        if (r_esc) begin
            wire_byte = (raw == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
            finishing = 1'b1;
        end else if (need_esc) begin
            wire_byte = ESC_BYTE;
            finishing = 1'b0;
        end else begin
            wire_byte = raw;
            finishing = 1'b1;
        end

        has_next = (step < STEP_HDR_LAST) ||
                   ((step == STEP_HDR_LAST) && (i_cmd.has_data || i_cmd.last_item)) ||
                   ((step == STEP_DATA) && i_cmd.last_item) ||
                   (step == STEP_CHK);

        if (step < STEP_HDR_LAST) begin
            step_next = step + 4'd1;
        end else if ((step == STEP_HDR_LAST) && i_cmd.has_data) begin
            step_next = STEP_DATA;
        end else if (step == STEP_CHK) begin
            step_next = STEP_CLOSE;
        end else begin
            step_next = STEP_CHK;
        end

        final_byte = finishing && !has_next;
    end

    assign o_cmd_pop = adv && final_byte;
    assign o_item    = r_out;
    assign o_empty   = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_byte  <= wire_byte;
            r_out.run_last  <= final_byte;
            r_out.frame_end <= (step == STEP_CLOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_esc       <= 1'b0;
            r_step      <= STEP_FLAG;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                if (finishing) begin
                    r_esc <= 1'b0;
                    if (final_byte) begin
                        r_mid <= 1'b0;
                    end else begin
                        r_mid  <= 1'b1;
                        r_step <= step_next;
                    end
                    if (step == STEP_FLAG) begin
                        r_xor <= '0;
                    end else if (is_content) begin
                        r_xor <= r_xor ^ raw;
                    end
                end else begin
                    r_esc  <= 1'b1;
                    r_mid  <= 1'b1;
                    r_step <= step;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/tracker_message_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_message_framer
// Frames telematics messages: flag, header, escaped body, XOR checksum, flag.
//
//   channel   direction  handshake                       payload
//   item      in         push / full                     i_item (t_in_item)
//   result    out        empty / pop                     o_item (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready       i_device_code_bcd
//
// The back half emits one wire byte per cycle while commands wait and the
// receiver keeps up; a request yields 1-30 bytes, escapes counted twice. The
// front accepts a request per cycle while the 4-entry command queue has room.
// Requests without bytes are absorbed in the front. Reset is synchronous; it
// clears the message state, sequence number, checksum and terminal id.
// ----------------------------------------------------------------------------
module tracker_message_framer import tmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  t_in_item         i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TID_W-1:0] i_device_code_bcd
);

    logic [TID_W-1:0] r_device_code;
    logic             cmd_push;
    t_cmd             cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    t_cmd             cmd_out;
    logic             cmd_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_code <= '0;
        end else if (i_cfg_valid) begin
            r_device_code <= i_device_code_bcd;
        end
    end

    tmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    tmf_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty)
    );

    tmf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_out),
        .i_cmd_empty   (cmd_empty),
        .o_cmd_pop     (cmd_pop),
        .i_device_code (r_device_code),
        .o_item        (o_item),
        .o_empty       (empty),
        .i_pop         (pop)
    );

endmodule

// ===== tb/sv/tracker_message_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_message_framer_tb
// Self-checking bench for the message framer. A scoreboard object rebuilds
// every wire byte from the accepted requests and compares the result stream
// byte by byte. A directed set covers escapes, checksum escapes, stray and
// abandoned messages. Random frames follow, with bursty input, a patterned
// receiver, one long receiver hold-off and terminal id changes between phases.
// ----------------------------------------------------------------------------
module tracker_message_framer_tb;
    import tmf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int REPORT_CAP      = 50;

    class frame_byte_tracker;
        logic [TID_W-1:0] device_code;
        logic [15:0]      seq_num;
        logic [7:0]       running_xor;
        bit               in_message;
        t_out_item        wire_bytes_due[$];
        t_out_item        request_bytes[$];
        int unsigned      mismatches;
        int unsigned      bytes_checked;
        int unsigned      frames_opened;
        int unsigned      frames_closed;

        function new();
            device_code   = '0;
            seq_num       = '0;
            running_xor   = '0;
            in_message    = 1'b0;
            mismatches    = 0;
            bytes_checked = 0;
            frames_opened = 0;
            frames_closed = 0;
        endfunction

        function void put_raw(logic [7:0] b, bit is_end);
            t_out_item o;
            o.out_byte  = b;
            o.run_last  = 1'b0;
            o.frame_end = is_end;
            request_bytes.push_back(o);
        endfunction

        function void put_escaped(logic [7:0] b);
            if (b == FLAG_BYTE) begin
                put_raw(ESC_BYTE, 1'b0);
                put_raw(ESC_FLAG, 1'b0);
            end else if (b == ESC_BYTE) begin
                put_raw(ESC_BYTE, 1'b0);
                put_raw(ESC_ESC, 1'b0);
            end else begin
                put_raw(b, 1'b0);
            end
        endfunction

        function void put_content(logic [7:0] b);
            running_xor = running_xor ^ b;
            put_escaped(b);
        endfunction

        function void note_request(t_in_item it);
            t_out_item o;
            int        idx;
            request_bytes.delete();
            if (it.first_item) begin
                in_message  = 1'b1;
                running_xor = '0;
                frames_opened++;
                put_raw(FLAG_BYTE, 1'b0);
                put_content(it.message_id[15:8]);
                put_content(it.message_id[7:0]);
                put_content(it.attribute_word[15:8]);
                put_content(it.attribute_word[7:0]);
                for (int i = 5; i >= 0; i--) put_content(device_code[8*i +: 8]);
                put_content(seq_num[15:8]);
                put_content(seq_num[7:0]);
                seq_num = seq_num + 16'd1;
            end
            if (!in_message) return;
            if (it.has_data) put_content(it.data_byte);
            if (it.last_item) begin
                put_escaped(running_xor);
                put_raw(FLAG_BYTE, 1'b1);
                in_message  = 1'b0;
                running_xor = '0;
                frames_closed++;
            end
            if (request_bytes.size() > 0) begin
                idx = request_bytes.size() - 1;
                o = request_bytes[idx];
                o.run_last = 1'b1;
                request_bytes[idx] = o;
            end
            foreach (request_bytes[k]) wire_bytes_due.push_back(request_bytes[k]);
        endfunction

        function void check_wire_byte(t_out_item got);
            t_out_item want;
            bytes_checked++;
            if (wire_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected byte: expected none, got %02h run_last %0b end %0b",
                             $time, got.out_byte, got.run_last, got.frame_end);
                return;
            end
            want = wire_bytes_due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, want.out_byte, got.out_byte);
            end
            if (got.run_last !== want.run_last) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: run_last expected %0b, got %0b (byte %02h)",
                             $time, want.run_last, got.run_last, want.out_byte);
            end
            if (got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: frame_end expected %0b, got %0b (byte %02h)",
                             $time, want.frame_end, got.frame_end, want.out_byte);
            end
        endfunction
    endclass

    logic             i_clk             = 1'b0;
    logic             i_rst_n           = 1'b0;
    logic             push              = 1'b0;
    t_in_item         i_item            = '0;
    logic             pop               = 1'b0;
    logic             i_cfg_valid       = 1'b0;
    logic [TID_W-1:0] i_device_code_bcd = '0;
    logic             full;
    logic             empty;
    logic             o_cfg_ready;
    t_out_item        o_item;

    frame_byte_tracker tracker = new();
    int unsigned       stall_cycles  = 0;
    int unsigned       requests_sent = 0;
    int unsigned       cfg_writes    = 0;
    int                burst_left    = 0;
    bit                hold_off_req  = 1'b0;

    always #2 i_clk = ~i_clk;

    tracker_message_framer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .i_item            (i_item),
        .full              (full),
        .empty             (empty),
        .pop               (pop),
        .o_item            (o_item),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_device_code_bcd (i_device_code_bcd)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) tracker.check_wire_byte(o_item);
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tracker_message_framer regression: fail");
        $finish;
    end

    // receiver: segments of differing pop patterns, plus one requested hold-off
    initial begin
        int seg;
        int mode;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 4);
                seg  = $urandom_range(4, 60);
                for (int c = 0; c < seg; c++) begin
                    case (mode)
                        0, 1: begin
                            pop <= 1'b1;
                        end
                        2: begin
                            pop <= 1'($urandom_range(0, 1));
                        end
                        3: begin
                            pop <= ($urandom_range(0, 3) == 0);
                        end
                        default: begin
                            pop <= (c % 3 != 2);
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_in_item make_item(logic [15:0] msg, logic [15:0] attr,
                                           logic [7:0] data, bit has, bit first, bit last);
        t_in_item it;
        it.message_id     = msg;
        it.attribute_word = attr;
        it.data_byte      = data;
        it.has_data       = has;
        it.first_item     = first;
        it.last_item      = last;
        return it;
    endfunction

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 3))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item random_item();
        return make_item(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         body_byte(), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    endfunction

    task automatic send_request(input t_in_item it);
        bit counts;
        counts = it.first_item || tracker.in_message;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        burst_left--;
        tracker.note_request(it);
        if (counts) requests_sent++;
    endtask

    task automatic write_device_code(input logic [TID_W-1:0] v);
        i_device_code_bcd <= v;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.device_code = v;
        cfg_writes++;
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        burst_left = 0;
        while (tracker.wire_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // empty body, then a stray byte outside any message
        send_request(make_item(16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1));
        send_request(make_item(16'h0000, 16'h0000, FLAG_BYTE, 1'b1, 1'b0, 1'b0));
        // extreme header words, escaped body bytes, an idle request
        send_request(make_item(16'hFFFF, 16'hFFFF, 8'h00, 1'b1, 1'b1, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, FLAG_BYTE, 1'b1, 1'b0, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, ESC_BYTE, 1'b1, 1'b0, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, ESC_BYTE, 1'b1, 1'b0, 1'b1));
        // checksum equal to the flag, then equal to the escape byte
        send_request(make_item({FLAG_BYTE, ESC_BYTE}, {ESC_BYTE, FLAG_BYTE}, 8'h00,
                               1'b0, 1'b1, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, tracker.running_xor ^ FLAG_BYTE,
                               1'b1, 1'b0, 1'b1));
        send_request(make_item(16'h1234, 16'h0001, 8'h55, 1'b1, 1'b1, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, tracker.running_xor ^ ESC_BYTE,
                               1'b1, 1'b0, 1'b1));
        // new message while one is open
        send_request(make_item(16'h0100, 16'h0003, 8'hAA, 1'b1, 1'b1, 1'b0));
        send_request(make_item(16'h0200, 16'h0000, FLAG_BYTE, 1'b1, 1'b1, 1'b0));
        send_request(make_item(16'h0000, 16'h0000, 8'h01, 1'b1, 1'b0, 1'b1));
        send_request(make_item(16'h0102, 16'h0304, FLAG_BYTE, 1'b1, 1'b1, 1'b1));
        // closing request with no open message
        send_request(make_item(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic send_random_message();
        int       kind;
        int       n;
        t_in_item it;
        kind = $urandom_range(0, 19);
        it   = random_item();
        if (kind == 0) begin
            it.last_item = 1'($urandom_range(0, 1));
            send_request(it);
        end else if (kind == 1) begin
            it.first_item = 1'b1;
            it.last_item  = 1'b1;
            send_request(it);
        end else begin
            it.first_item = 1'b1;
            send_request(it);
            n = $urandom_range(0, 6);
            repeat (n) begin
                it = random_item();
                it.has_data = ($urandom_range(0, 7) != 0);
                send_request(it);
            end
            // kind 2 leaves the message open so the next start abandons it
            if (kind != 2) begin
                it = random_item();
                it.last_item = 1'b1;
                send_request(it);
            end
        end
    endtask

    initial begin
        int unsigned      phase_start;
        logic [TID_W-1:0] tid;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_device_code(48'h7E7D_0139_7D7E);
        run_directed();
        for (int phase = 0; phase < 4; phase++) begin
            wait_until_drained();
            case (phase)
                0:       tid = 48'hFFFF_FFFF_FFFF;
                1:       tid = 48'h0000_0000_0000;
                2:       tid = 48'h0139_1234_5678;
                default: tid = 48'({$urandom, $urandom});
            endcase
            write_device_code(tid);
            if (phase == 1) hold_off_req = 1'b1;
            phase_start = requests_sent;
            while (requests_sent - phase_start < ITEMS_PER_PHASE) send_random_message();
        end
        wait_until_drained();
        $display("covered %0d requests, %0d frames opened, %0d closed, %0d bytes checked",
                 requests_sent, tracker.frames_opened, tracker.frames_closed,
                 tracker.bytes_checked);
        $display("%0d terminal id writes, one long receiver hold-off with input back-pressure",
                 cfg_writes);
        if (tracker.mismatches == 0 && tracker.wire_bytes_due.size() == 0) begin
            $display("tracker_message_framer regression: pass");
        end else begin
            $display("%0d mismatches, %0d bytes never seen", tracker.mismatches,
                     tracker.wire_bytes_due.size());
            $display("tracker_message_framer regression: fail");
        end
        $finish;
    end

endmodule
